[rtl/bppag_pkg.sv]
// Package for the block pack/permute address generator.
// Holds the configuration register indexes, pack mode codes and the walk flag type.
// No dependencies.
package bppag_pkg;

    localparam int unsigned CFG_INDEX_BITS = 3;

    localparam logic [CFG_INDEX_BITS-1:0] REG_BLOCK_START   = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_BLOCK_SIZE    = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_GRID_DIM      = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ELEMENT_WIDTH = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PACK_MODE     = 3'd4;

    localparam logic [1:0] MODE_PACK     = 2'd0;
    localparam logic [1:0] MODE_PERMUTE1 = 2'd1;
    localparam logic [1:0] MODE_PERMUTE2 = 2'd2;
    localparam logic [1:0] MODE_UNPACK   = 2'd3;

    localparam logic [1:0] EW_RESET = 2'd1;

    typedef struct packed {
        logic valid_res;
        logic last;
    } t_walk_flags;

endpackage

[rtl/block_pack_permute_address_gen.sv]
// Top level of the block pack/permute address generator.
// Depends on bppag_pkg and bppag_walk.
//
// Each accepted request yields one source/destination word index pair for moving a 3D
// sub-block between a full grid and a compact buffer, walking slow, mid, fast, then word.
// A new request is accepted every cycle while the output is not stalled; the two chained
// multiplications of the index arithmetic are split over two register stages, followed by
// the output register. Configuration writes take effect at once and must only be made while
// no request is in flight.
module block_pack_permute_address_gen
    import bppag_pkg::*;
#(
    parameter int unsigned AXIS_BITS  = 10,
    parameter int unsigned INDEX_BITS = 31
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [3*AXIS_BITS-1:0]  i_cfg_data,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic                    i_restart,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [INDEX_BITS-1:0]   o_src_index,
    output logic [INDEX_BITS-1:0]   o_dst_index,
    output logic                    o_last,
    output logic                    o_valid_res
);

    localparam int unsigned A = AXIS_BITS;
    localparam int unsigned N = INDEX_BITS;

    // Configuration registers.
    logic [3*A-1:0] r_block_start, r_block_size, r_grid_dim;
    logic [1:0]     r_element_width, r_pack_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_start   <= '0;
            r_block_size    <= '0;
            r_grid_dim      <= '0;
            r_element_width <= EW_RESET;
            r_pack_mode     <= MODE_PACK;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_BLOCK_START:   r_block_start   <= i_cfg_data;
                REG_BLOCK_SIZE:    r_block_size    <= i_cfg_data;
                REG_GRID_DIM:      r_grid_dim      <= i_cfg_data;
                REG_ELEMENT_WIDTH: r_element_width <= i_cfg_data[1:0];
                REG_PACK_MODE:     r_pack_mode     <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    logic [A-1:0] s0, s1, s2, b0, b1, b2, d1, d2;
    logic         ew2;

    assign s0  = r_block_size[3*A-1:2*A];
    assign s1  = r_block_size[2*A-1:A];
    assign s2  = r_block_size[A-1:0];
    assign b0  = r_block_start[3*A-1:2*A];
    assign b1  = r_block_start[2*A-1:A];
    assign b2  = r_block_start[A-1:0];
    assign d1  = r_grid_dim[2*A-1:A];
    assign d2  = r_grid_dim[A-1:0];
    assign ew2 = r_element_width[1];

    // Pipeline flow control.
    logic r1_v, r2_v, r_out_v;
    logic en1, en2, en_out, accept;

    assign en_out     = !r_out_v || i_out_ready;
    assign en2        = !r2_v || en_out;
    assign en1        = !r1_v || en2;
    assign o_in_ready = en1;
    assign accept     = i_in_valid && en1;

    // Walk counters.
    logic [A-1:0] cur_slow, cur_mid, cur_fast;
    logic         cur_word;
    t_walk_flags  walk_flags;

    bppag_walk #(
        .AXIS_BITS (A)
    ) u_walk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (accept),
        .i_restart   (i_restart),
        .i_size_slow (s0),
        .i_size_mid  (s1),
        .i_size_fast (s2),
        .i_ew2       (ew2),
        .o_slow      (cur_slow),
        .o_mid       (cur_mid),
        .o_fast      (cur_fast),
        .o_word      (cur_word),
        .o_flags     (walk_flags)
    );

    // Packed index is a + X*(b + Y*c); the mode picks which counters and extents play
    // each role.
    logic [A-1:0] sel_a, sel_b, sel_c, sel_x, sel_y;

    always_comb begin
        case (r_pack_mode)
            MODE_PERMUTE1: begin
                sel_a = cur_slow; sel_x = s0; sel_b = cur_fast; sel_y = s2; sel_c = cur_mid;
            end
            MODE_PERMUTE2: begin
                sel_a = cur_mid; sel_x = s1; sel_b = cur_slow; sel_y = s0; sel_c = cur_fast;
            end
            default: begin
                sel_a = cur_fast; sel_x = s2; sel_b = cur_mid; sel_y = s1; sel_c = cur_slow;
            end
        endcase
    end

    // Stage 1: first products.
    logic [A:0]   n1_b0s;
    logic [2*A:0] n1_t1;
    logic [2*A-1:0] n1_yc;

    assign n1_b0s = (A+1)'(b0) + (A+1)'(cur_slow);
    assign n1_t1  = (2*A+1)'(d1) * (2*A+1)'(n1_b0s);
    assign n1_yc  = (2*A)'(sel_y) * (2*A)'(sel_c);

    t_walk_flags    r1_flags;
    logic           r1_word;
    logic [A-1:0]   r1_a, r1_b, r1_x;
    logic [2*A-1:0] r1_yc;
    logic [2*A:0]   r1_t1;
    logic [A:0]     r1_b1m, r1_b2f;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (en1) begin
            r1_v <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_flags <= walk_flags;
            r1_word  <= cur_word;
            r1_a     <= sel_a;
            r1_b     <= sel_b;
            r1_x     <= sel_x;
            r1_yc    <= n1_yc;
            r1_t1    <= n1_t1;
            r1_b1m   <= (A+1)'(b1) + (A+1)'(cur_mid);
            r1_b2f   <= (A+1)'(b2) + (A+1)'(cur_fast);
        end
    end

    // Stage 2: second products, taken modulo the index width.
    logic [N-1:0] n2_gsum, n2_grid, n2_psum, n2_pack;

    assign n2_gsum = N'(r1_b1m) + N'(r1_t1);
    assign n2_grid = N'(r1_b2f) + N'(d2) * n2_gsum;
    assign n2_psum = N'(r1_b) + N'(r1_yc);
    assign n2_pack = N'(r1_a) + N'(r1_x) * n2_psum;

    t_walk_flags  r2_flags;
    logic         r2_word;
    logic [N-1:0] r2_grid, r2_pack;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (en2) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r2_flags <= r1_flags;
            r2_word  <= r1_word;
            r2_grid  <= n2_grid;
            r2_pack  <= n2_pack;
        end
    end

    // Output stage: scale by element width, add the word offset, route by mode, zero invalid results.
    logic [N-1:0] fin_grid, fin_pack, n_src, n_dst;

    assign fin_grid = (ew2 ? {r2_grid[N-2:0], 1'b0} : r2_grid) + N'(r2_word);
    assign fin_pack = (ew2 ? {r2_pack[N-2:0], 1'b0} : r2_pack) + N'(r2_word);

    always_comb begin
        if (!r2_flags.valid_res) begin
            n_src = '0;
            n_dst = '0;
        end else if (r_pack_mode == MODE_UNPACK) begin
            n_src = fin_pack;
            n_dst = fin_grid;
        end else begin
            n_src = fin_grid;
            n_dst = fin_pack;
        end
    end

    logic [N-1:0] r_src, r_dst;
    logic         r_last, r_valid_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en_out) begin
            r_out_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_out) begin
            r_src       <= n_src;
            r_dst       <= n_dst;
            r_last      <= r2_flags.last;
            r_valid_res <= r2_flags.valid_res;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_src_index = r_src;
    assign o_dst_index = r_dst;
    assign o_last      = r_last;
    assign o_valid_res = r_valid_res;

endmodule

[rtl/bppag_walk.sv]
// Block walk counters for the block pack/permute address generator.
// Steps word, fast, mid and slow counters once per request. Depends on bppag_pkg.
module bppag_walk
    import bppag_pkg::*;
#(
    parameter int unsigned AXIS_BITS = 10
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  logic                 i_restart,
    input  logic [AXIS_BITS-1:0] i_size_slow,
    input  logic [AXIS_BITS-1:0] i_size_mid,
    input  logic [AXIS_BITS-1:0] i_size_fast,
    input  logic                 i_ew2,
    output logic [AXIS_BITS-1:0] o_slow,
    output logic [AXIS_BITS-1:0] o_mid,
    output logic [AXIS_BITS-1:0] o_fast,
    output logic                 o_word,
    output t_walk_flags          o_flags
);

    logic [AXIS_BITS-1:0] r_slow, r_mid, r_fast;
    logic                 r_word;
    logic [AXIS_BITS-1:0] n_slow, n_mid, n_fast;
    logic                 n_word;
    logic [AXIS_BITS-1:0] cur_slow, cur_mid, cur_fast;
    logic                 cur_word;
    logic                 zero_ext;
    logic                 w_end, f_end, m_end, s_end;

    assign zero_ext = (i_size_slow == '0) || (i_size_mid == '0) || (i_size_fast == '0);

    // A restart starts the walk at the origin; a zero extent parks the counters at the origin.
    assign cur_slow = (i_restart || zero_ext) ? '0 : r_slow;
    assign cur_mid  = (i_restart || zero_ext) ? '0 : r_mid;
    assign cur_fast = (i_restart || zero_ext) ? '0 : r_fast;
    assign cur_word = (i_restart || zero_ext) ? 1'b0 : r_word;

    // Counters at or past their last value count as at it, so the walk wraps.
    assign w_end = !i_ew2 || cur_word;
    assign f_end = ({1'b0, cur_fast} + 1'b1) >= {1'b0, i_size_fast};
    assign m_end = ({1'b0, cur_mid} + 1'b1) >= {1'b0, i_size_mid};
    assign s_end = ({1'b0, cur_slow} + 1'b1) >= {1'b0, i_size_slow};

    always_comb begin
        n_slow = cur_slow;
        n_mid  = cur_mid;
        n_fast = cur_fast;
        n_word = cur_word;
        if (zero_ext) begin
            n_slow = '0;
            n_mid  = '0;
            n_fast = '0;
            n_word = 1'b0;
        end else if (!w_end) begin
            n_word = 1'b1;
        end else begin
            n_word = 1'b0;
            if (!f_end) begin
                n_fast = cur_fast + 1'b1;
            end else begin
                n_fast = '0;
                if (!m_end) begin
                    n_mid = cur_mid + 1'b1;
                end else begin
                    n_mid  = '0;
                    n_slow = s_end ? '0 : cur_slow + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slow <= '0;
            r_mid  <= '0;
            r_fast <= '0;
            r_word <= 1'b0;
        end else if (i_step) begin
            r_slow <= n_slow;
            r_mid  <= n_mid;
            r_fast <= n_fast;
            r_word <= n_word;
        end
    end

    assign o_slow            = cur_slow;
    assign o_mid             = cur_mid;
    assign o_fast            = cur_fast;
    assign o_word            = cur_word;
    assign o_flags.valid_res = !zero_ext;
    assign o_flags.last      = !zero_ext && w_end && f_end && m_end && s_end;

endmodule

[test/block_pack_permute_address_gen_checker.sv]
// Checker for the block pack/permute address generator: tracks register writes,
// predicts the source/destination index pair of every request and compares results.
// Depends on bppag_pkg.
`timescale 1ns / 1ps

module block_pack_permute_address_gen_checker
    import bppag_pkg::*;
#(
    parameter int unsigned AXIS_BITS  = 10,
    parameter int unsigned INDEX_BITS = 31
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [3*AXIS_BITS-1:0]    i_cfg_data,
    input  logic                      i_in_valid,
    input  logic                      i_in_ready,
    input  logic                      i_restart,
    input  logic                      i_out_valid,
    input  logic                      i_out_ready,
    input  logic [INDEX_BITS-1:0]     i_src_index,
    input  logic [INDEX_BITS-1:0]     i_dst_index,
    input  logic                      i_last,
    input  logic                      i_valid_res,
    output int                        o_error_count,
    output int                        o_pending
);

    typedef struct packed {
        logic [INDEX_BITS-1:0] src;
        logic [INDEX_BITS-1:0] dst;
        logic                  last;
        logic                  valid_res;
    } t_addr_pair;

    logic [3*AXIS_BITS-1:0] start_reg, size_reg, dim_reg;
    logic [1:0]             ew_reg, mode_reg;
    logic [AXIS_BITS-1:0]   slow_cnt, mid_cnt, fast_cnt;
    logic                   word_cnt;
    t_addr_pair             pair_q[$];

    task automatic report_mismatch(input string msg);
        $display("%0t: mismatch: %s", $realtime, msg);
        o_error_count++;
    endtask

    // Computes the index pair for one request and advances the block walk.
    task automatic walk_step(input logic restart, output t_addr_pair pair);
        longint unsigned s0, s1, s2, b0, b1, b2, d1, d2, ew, grid_idx, buf_idx;
        logic w_end, f_end, m_end, s_end;
        s0 = size_reg[3*AXIS_BITS-1 -: AXIS_BITS];
        s1 = size_reg[2*AXIS_BITS-1 -: AXIS_BITS];
        s2 = size_reg[AXIS_BITS-1:0];
        b0 = start_reg[3*AXIS_BITS-1 -: AXIS_BITS];
        b1 = start_reg[2*AXIS_BITS-1 -: AXIS_BITS];
        b2 = start_reg[AXIS_BITS-1:0];
        d1 = dim_reg[2*AXIS_BITS-1 -: AXIS_BITS];
        d2 = dim_reg[AXIS_BITS-1:0];
        ew = ew_reg[1] ? 2 : 1;
        if (restart) begin
            slow_cnt = '0;
            mid_cnt  = '0;
            fast_cnt = '0;
            word_cnt = 1'b0;
        end
        // A block with any zero extent parks the walk and flags the result.
        if (s0 == 0 || s1 == 0 || s2 == 0) begin
            slow_cnt = '0;
            mid_cnt  = '0;
            fast_cnt = '0;
            word_cnt = 1'b0;
            pair = '0;
            return;
        end
        grid_idx = ew * ((b2 + fast_cnt) + d2 * ((b1 + mid_cnt) + d1 * (b0 + slow_cnt)))
                   + word_cnt;
        case (mode_reg)
            MODE_PERMUTE1: buf_idx = ew * (slow_cnt + s0 * (fast_cnt + s2 * mid_cnt));
            MODE_PERMUTE2: buf_idx = ew * (mid_cnt + s1 * (slow_cnt + s0 * fast_cnt));
            default:       buf_idx = ew * (fast_cnt + s2 * (mid_cnt + s1 * slow_cnt));
        endcase
        buf_idx = buf_idx + word_cnt;
        // Counters left beyond a lowered extent count as being at their last value.
        w_end = (word_cnt + 64'd1 >= ew);
        f_end = (fast_cnt + 64'd1 >= s2);
        m_end = (mid_cnt + 64'd1 >= s1);
        s_end = (slow_cnt + 64'd1 >= s0);
        pair.last = w_end && f_end && m_end && s_end;
        pair.valid_res = 1'b1;
        if (mode_reg == MODE_UNPACK) begin
            pair.src = buf_idx[INDEX_BITS-1:0];
            pair.dst = grid_idx[INDEX_BITS-1:0];
        end else begin
            pair.src = grid_idx[INDEX_BITS-1:0];
            pair.dst = buf_idx[INDEX_BITS-1:0];
        end
        if (!w_end) begin
            word_cnt = 1'b1;
        end else begin
            word_cnt = 1'b0;
            if (!f_end) begin
                fast_cnt = fast_cnt + 1'b1;
            end else begin
                fast_cnt = '0;
                if (!m_end) begin
                    mid_cnt = mid_cnt + 1'b1;
                end else begin
                    mid_cnt  = '0;
                    slow_cnt = s_end ? '0 : slow_cnt + 1'b1;
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_addr_pair want;
        if (!i_rst_n) begin
            start_reg = '0;
            size_reg  = '0;
            dim_reg   = '0;
            ew_reg    = EW_RESET;
            mode_reg  = MODE_PACK;
            slow_cnt  = '0;
            mid_cnt   = '0;
            fast_cnt  = '0;
            word_cnt  = 1'b0;
            pair_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_BLOCK_START:   start_reg = i_cfg_data;
                    REG_BLOCK_SIZE:    size_reg  = i_cfg_data;
                    REG_GRID_DIM:      dim_reg   = i_cfg_data;
                    REG_ELEMENT_WIDTH: ew_reg    = i_cfg_data[1:0];
                    REG_PACK_MODE:     mode_reg  = i_cfg_data[1:0];
                    default: ;
                endcase
            end
            // Results are matched before the new request is queued, so a result that
            // overtakes its own request is caught as unexpected.
            if (i_out_valid && i_out_ready) begin
                if (pair_q.size() == 0) begin
                    report_mismatch($sformatf("result with no request waiting, src %0d dst %0d",
                                              i_src_index, i_dst_index));
                end else begin
                    want = pair_q.pop_front();
                    if (i_src_index !== want.src)
                        report_mismatch($sformatf("src_index expected %0d, got %0d",
                                                  want.src, i_src_index));
                    if (i_dst_index !== want.dst)
                        report_mismatch($sformatf("dst_index expected %0d, got %0d",
                                                  want.dst, i_dst_index));
                    if (i_last !== want.last)
                        report_mismatch($sformatf("last expected %0b, got %0b",
                                                  want.last, i_last));
                    if (i_valid_res !== want.valid_res)
                        report_mismatch($sformatf("valid_res expected %0b, got %0b",
                                                  want.valid_res, i_valid_res));
                end
            end
            if (i_in_valid && i_in_ready) begin
                walk_step(i_restart, want);
                pair_q.push_back(want);
            end
        end
        o_pending <= pair_q.size();
    end

endmodule

[test/block_pack_permute_address_gen_tb.sv]
// Testbench top for the block pack/permute address generator: clock, reset, register
// setup and request/result traffic, with the verdict taken from the checker.
// Depends on bppag_pkg, block_pack_permute_address_gen and its checker.
`timescale 1ns / 1ps

module block_pack_permute_address_gen_tb;
    import bppag_pkg::*;

    localparam int unsigned AXIS_BITS      = 10;
    localparam int unsigned INDEX_BITS     = 31;
    localparam int          REQUEST_TARGET = 1700;
    localparam int          DRAIN_CYCLES   = 12;
    localparam int          AXIS_MAX       = (1 << AXIS_BITS) - 1;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_cfg_we;
    logic [CFG_INDEX_BITS-1:0] i_cfg_index;
    logic [3*AXIS_BITS-1:0]    i_cfg_data;
    logic                      i_in_valid;
    logic                      o_in_ready;
    logic                      i_restart;
    logic                      o_out_valid;
    logic                      i_out_ready;
    logic [INDEX_BITS-1:0]     o_src_index;
    logic [INDEX_BITS-1:0]     o_dst_index;
    logic                      o_last;
    logic                      o_valid_res;

    int error_count;
    int pending_count;
    int sender_idle_pct;
    int receiver_idle_pct;
    int hold_cycles;

    block_pack_permute_address_gen #(
        .AXIS_BITS (AXIS_BITS),
        .INDEX_BITS(INDEX_BITS)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_restart  (i_restart),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_src_index(o_src_index),
        .o_dst_index(o_dst_index),
        .o_last     (o_last),
        .o_valid_res(o_valid_res)
    );

    block_pack_permute_address_gen_checker #(
        .AXIS_BITS (AXIS_BITS),
        .INDEX_BITS(INDEX_BITS)
    ) i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_restart    (i_restart),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_src_index  (o_src_index),
        .i_dst_index  (o_dst_index),
        .i_last       (o_last),
        .i_valid_res  (o_valid_res),
        .o_error_count(error_count),
        .o_pending    (pending_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("[block_pack_permute_address_gen] ERROR");
        $finish;
    end

    // Receiver: random stalls, plus a long hold-off whenever hold_cycles is loaded.
    initial begin
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_cycles > 0) begin
                hold_cycles--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= receiver_idle_pct);
            end
        end
    end

    function automatic logic [3*AXIS_BITS-1:0] axes(input int slow, mid, fast);
        return {AXIS_BITS'(slow), AXIS_BITS'(mid), AXIS_BITS'(fast)};
    endfunction

    function automatic int rand_extent();
        int pick;
        pick = $urandom_range(99);
        if (pick < 4)
            return 0;
        if (pick < 8)
            return AXIS_MAX;
        return $urandom_range(1, 4);
    endfunction

    function automatic int rand_start();
        int pick;
        pick = $urandom_range(99);
        if (pick < 30)
            return $urandom_range(AXIS_MAX);
        if (pick < 40)
            return AXIS_MAX;
        return $urandom_range(7);
    endfunction

    function automatic int rand_dim();
        int pick;
        pick = $urandom_range(99);
        if (pick < 40)
            return $urandom_range(AXIS_MAX);
        if (pick < 50)
            return $urandom_range(1) ? AXIS_MAX : 0;
        return $urandom_range(1, 16);
    endfunction

    // Returns once the checker holds no outstanding request.
    task automatic wait_for_results();
        do @(posedge i_clk); while (pending_count != 0);
    endtask

    task automatic cfg_write(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [3*AXIS_BITS-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
    endtask

    task automatic load_geometry(input logic [3*AXIS_BITS-1:0] start, size, dims,
                                 input logic [1:0] ew, mode);
        wait_for_results();
        cfg_write(REG_BLOCK_START, start);
        cfg_write(REG_BLOCK_SIZE, size);
        cfg_write(REG_GRID_DIM, dims);
        cfg_write(REG_ELEMENT_WIDTH, {{(3*AXIS_BITS-2){1'b0}}, ew});
        cfg_write(REG_PACK_MODE, {{(3*AXIS_BITS-2){1'b0}}, mode});
        i_cfg_we <= 1'b0;
    endtask

    // Offers one request after a random gap and returns at the edge that accepts it.
    task automatic issue_request(input logic restart);
        while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_restart  <= restart;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
    endtask

    task automatic issue_walk(input int count, input logic restart_first, input int restart_pct);
        for (int k = 0; k < count; k++)
            issue_request(k == 0 ? restart_first : ($urandom_range(99) < restart_pct));
        i_in_valid <= 1'b0;
    endtask

    initial begin
        int phase_sent;
        int burst;
        bit held;
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= REG_BLOCK_START;
        i_cfg_data  <= '0;
        i_in_valid  <= 1'b0;
        i_restart   <= 1'b0;
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        hold_cycles       = 0;
        held              = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings have zero extents, so results come back flagged invalid.
        issue_walk(2, 1'b0, 100);
        // Block at the far corner of the largest grid; an element width of three acts as
        // two.
        load_geometry(axes(AXIS_MAX, AXIS_MAX, AXIS_MAX), axes(1, 1, 2),
                      axes(AXIS_MAX, AXIS_MAX, AXIS_MAX), 2'd3, MODE_UNPACK);
        issue_walk(5, 1'b1, 0);
        // Largest extents on an empty grid; an element width of zero acts as one.
        load_geometry(axes(0, 0, 0), axes(AXIS_MAX, AXIS_MAX, AXIS_MAX), axes(0, 0, 0),
                      2'd0, MODE_PACK);
        issue_walk(3, 1'b1, 0);
        issue_walk(1, 1'b1, 0);
        load_geometry(axes(1, 2, 3), axes(2, 2, 2), axes(5, 6, 7), 2'd1, MODE_PERMUTE1);
        issue_walk(6, 1'b1, 0);
        load_geometry(axes(1, 2, 3), axes(2, 2, 2), axes(5, 6, 7), 2'd2, MODE_PERMUTE2);
        issue_walk(5, 1'b0, 0);
        // Extents lowered in the middle of a walk leave the counters out of range.
        load_geometry(axes(3, 1, 4), axes(1, 1, 1), axes(9, 8, 7), 2'd1, MODE_PACK);
        issue_walk(2, 1'b0, 0);
        load_geometry(axes(3, 1, 4), axes(3, 0, 2), axes(9, 8, 7), 2'd2, MODE_PERMUTE1);
        issue_walk(2, 1'b0, 0);

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    sender_idle_pct   = 17;
                    receiver_idle_pct = 75;
                end
                1: begin
                    sender_idle_pct   = 75;
                    receiver_idle_pct = 17;
                end
                default: begin
                    sender_idle_pct   = 0;
                    receiver_idle_pct = 0;
                end
            endcase
            phase_sent = 0;
            while (phase_sent < REQUEST_TARGET / 3) begin
                burst = $urandom_range(15, 60);
                load_geometry(axes(rand_start(), rand_start(), rand_start()),
                              axes(rand_extent(), rand_extent(), rand_extent()),
                              axes(rand_dim(), rand_dim(), rand_dim()),
                              2'($urandom_range(3)), 2'($urandom_range(3)));
                // Hold the receiver off while requests keep coming, so the block fills
                // up and stalls its input.
                if (phase == 2 && !held) begin
                    held        = 1'b1;
                    hold_cycles = 300;
                    burst       = 80;
                end
                issue_walk(burst, 1'($urandom_range(1)), 3);
                phase_sent += burst;
            end
        end

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("[block_pack_permute_address_gen] OK");
        else
            $display("[block_pack_permute_address_gen] ERROR");
        $finish;
    end

endmodule

[filelist.f]
rtl/bppag_pkg.sv
rtl/bppag_walk.sv
rtl/block_pack_permute_address_gen.sv
test/block_pack_permute_address_gen_checker.sv
test/block_pack_permute_address_gen_tb.sv
